### rtl/hvn_pkg.sv
package hvn_pkg;

  localparam int MAX_SIDE_DEF = 256;
  localparam int SIDE_W = 9;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd256;
  localparam logic REG_SIDE = 1'b0;

  // Fixed arithmetic widths.
  localparam int SUM_W = 20;
  localparam int SQ_W = 40;
  localparam int RAD_W = 64;
  localparam int LEN_W = 32;
  localparam int REM_W = 48;
  localparam int QUO_W = 16;
  localparam int DIV_SHIFT = 27;
  localparam int ITER_W = 5;
  localparam logic [ITER_W-1:0] SQRT_STEPS_M1 = 5'd31;
  localparam logic [ITER_W-1:0] DIV_STEPS_M1 = 5'd15;
  localparam logic [15:0] UNIT_Q14 = 16'd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_SUM,
    ST_SQ,
    ST_QSUM,
    ST_SQRT,
    ST_DIVI,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic shift;
    logic sum;
    logic sq;
    logic qsum;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic has_pend;
    logic iter_last;
    logic out_free;
  } stat_t;

endpackage

### rtl/hvn_ram.sv
module hvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/hvn_ctrl.sv
module hvn_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  hvn_pkg::stat_t stat,
  output hvn_pkg::cmd_t  cmd
);

  hvn_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hvn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      hvn_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = hvn_pkg::ST_READ;
        end
      end
      hvn_pkg::ST_READ: begin
        state_next = hvn_pkg::ST_SHIFT;
      end
      hvn_pkg::ST_SHIFT: begin
        cmd.shift = 1'b1;
        state_next = hvn_pkg::ST_SUM;
      end
      hvn_pkg::ST_SUM: begin
        if (stat.has_pend) begin
          cmd.sum = 1'b1;
          state_next = hvn_pkg::ST_SQ;
        end else begin
          state_next = hvn_pkg::ST_IDLE;
        end
      end
      hvn_pkg::ST_SQ: begin
        cmd.sq = 1'b1;
        state_next = hvn_pkg::ST_QSUM;
      end
      hvn_pkg::ST_QSUM: begin
        cmd.qsum = 1'b1;
        state_next = hvn_pkg::ST_SQRT;
      end
      hvn_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.iter_last) begin
          state_next = hvn_pkg::ST_DIVI;
        end
      end
      hvn_pkg::ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_next = hvn_pkg::ST_DIV;
      end
      hvn_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.iter_last) begin
          state_next = hvn_pkg::ST_EMIT;
        end
      end
      hvn_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = hvn_pkg::ST_SUM;
        end
      end
      default: begin
        state_next = hvn_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/hvn_dp.sv
module hvn_dp #(
  parameter int MAX_SIDE = hvn_pkg::MAX_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hvn_pkg::cmd_t               cmd,
  output hvn_pkg::stat_t              stat,
  input  logic [hvn_pkg::SIDE_W-1:0]  side_length,
  input  logic                        cfg_wr,
  input  logic [15:0]                 s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata,
  output logic                        m_tlast,
  output logic                        m_tuser
);

  localparam int PW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = (SW > hvn_pkg::SIDE_W) ? SW : hvn_pkg::SIDE_W;
  localparam int SUM_W = hvn_pkg::SUM_W;
  localparam int SQ_W = hvn_pkg::SQ_W;
  localparam int RAD_W = hvn_pkg::RAD_W;
  localparam int LEN_W = hvn_pkg::LEN_W;
  localparam int REM_W = hvn_pkg::REM_W;
  localparam int QUO_W = hvn_pkg::QUO_W;

  // Effective side, clamped to 2..MAX_SIDE.
  logic [CW-1:0] side_w, side_eff;
  logic [PW-1:0] last_idx;

  always_comb begin
    side_w = CW'(side_length);
    if (side_w < CW'(2)) begin
      side_eff = CW'(2);
    end else if (side_w > CW'(MAX_SIDE)) begin
      side_eff = CW'(MAX_SIDE);
    end else begin
      side_eff = side_w;
    end
    last_idx = PW'(side_eff - CW'(1));
  end

  // Grid position and row buffers.
  logic [PW-1:0] row_pos, col_pos, r_item, c_item;
  logic signed [15:0] h_reg;
  logic [15:0] old_rd, prev_rd;

  hvn_ram #(.WIDTH(16), .DEPTH(MAX_SIDE)) u_older (
    .clk(clk), .we(cmd.shift), .waddr(col_pos), .wdata(prev_rd),
    .re(cmd.accept), .raddr(col_pos), .rdata(old_rd)
  );

  hvn_ram #(.WIDTH(16), .DEPTH(MAX_SIDE)) u_prev (
    .clk(clk), .we(cmd.shift), .waddr(col_pos), .wdata(h_reg),
    .re(cmd.accept), .raddr(col_pos), .rdata(prev_rd)
  );

  logic signed [15:0] win [3][3];
  logic [3:0] pend;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      h_reg <= s_tdata;
    end
    if (rst) begin
      for (int t = 0; t < 3; t++) begin
        for (int k = 0; k < 3; k++) begin
          win[t][k] <= '0;
        end
      end
    end else if (cmd.shift) begin
      for (int t = 0; t < 3; t++) begin
        win[t][0] <= win[t][1];
        win[t][1] <= win[t][2];
      end
      win[0][2] <= old_rd;
      win[1][2] <= prev_rd;
      win[2][2] <= h_reg;
      r_item <= row_pos;
      c_item <= col_pos;
    end
  end

  // Candidate vertex: lowest pending emission, in raster order.
  logic [1:0] sel;
  logic [3:0] sel_oh;
  logic [PW-1:0] vi, vj;
  logic [1:0] ti, kj;
  logic signed [15:0] wp [4][4];
  logic [1:0] bt [4];
  logic [1:0] bk [4];
  logic en [4];
  logic signed [SUM_W-1:0] dx_ab [4];
  logic signed [SUM_W-1:0] dx_de [4];
  logic signed [SUM_W-1:0] dz_ad [4];
  logic signed [SUM_W-1:0] dz_be [4];
  logic signed [SUM_W-1:0] sum_x, sum_z;
  logic [2:0] sum_n;

  function automatic logic signed [SUM_W-1:0] dif(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
    logic signed [SUM_W-1:0] ea, eb;
    ea = a;
    eb = b;
    return ea - eb;
  endfunction

  always_comb begin
    priority casez (pend)
      4'b???1: sel = 2'd0;
      4'b??10: sel = 2'd1;
      4'b?100: sel = 2'd2;
      default: sel = 2'd3;
    endcase
    sel_oh = 4'b0001 << sel;
    vi = sel[1] ? r_item : r_item - PW'(1);
    vj = sel[0] ? c_item : c_item - PW'(1);
    ti = sel[1] ? 2'd2 : 2'd1;
    kj = sel[0] ? 2'd2 : 2'd1;
    for (int t = 0; t < 4; t++) begin
      for (int k = 0; k < 4; k++) begin
        wp[t][k] = (t < 3 && k < 3) ? win[t][k] : '0;
      end
    end
    // Cells up-left, up-right, down-left, down-right of the vertex.
    bt[0] = ti - 2'd1; bk[0] = kj - 2'd1;
    bt[1] = ti - 2'd1; bk[1] = kj;
    bt[2] = ti;        bk[2] = kj - 2'd1;
    bt[3] = ti;        bk[3] = kj;
    en[0] = (vi != '0) && (vj != '0);
    en[1] = (vi != '0) && (vj != last_idx);
    en[2] = (vi != last_idx) && (vj != '0);
    en[3] = (vi != last_idx) && (vj != last_idx);
    for (int q = 0; q < 4; q++) begin
      dx_ab[q] = dif(wp[bt[q]][bk[q]], wp[bt[q]][bk[q] + 2'd1]);
      dx_de[q] = dif(wp[bt[q] + 2'd1][bk[q]], wp[bt[q] + 2'd1][bk[q] + 2'd1]);
      dz_ad[q] = dif(wp[bt[q]][bk[q]], wp[bt[q] + 2'd1][bk[q]]);
      dz_be[q] = dif(wp[bt[q]][bk[q] + 2'd1], wp[bt[q] + 2'd1][bk[q] + 2'd1]);
    end
    sum_x = (en[0] ? dx_de[0] : '0)
          + (en[1] ? dx_ab[1] + dx_de[1] : '0)
          + (en[2] ? dx_ab[2] + dx_de[2] : '0)
          + (en[3] ? dx_ab[3] : '0);
    sum_z = (en[0] ? dz_be[0] : '0)
          + (en[1] ? dz_ad[1] + dz_be[1] : '0)
          + (en[2] ? dz_ad[2] + dz_be[2] : '0)
          + (en[3] ? dz_ad[3] : '0);
    sum_n = (en[0] ? 3'd1 : 3'd0) + (en[1] ? 3'd2 : 3'd0)
          + (en[2] ? 3'd2 : 3'd0) + (en[3] ? 3'd1 : 3'd0);
  end

  // Position counter and pending emissions.
  logic r_first, c_first, r_last, c_last;

  assign r_first = (row_pos == '0);
  assign c_first = (col_pos == '0);
  assign r_last = (row_pos == last_idx);
  assign c_last = (col_pos == last_idx);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (cmd.shift) begin
      if (c_last) begin
        col_pos <= '0;
        row_pos <= r_last ? '0 : row_pos + PW'(1);
      end else begin
        col_pos <= col_pos + PW'(1);
      end
    end
    if (rst) begin
      pend <= '0;
    end else if (cmd.shift) begin
      pend <= {r_last && c_last,
               r_last && !c_first,
               !r_first && c_last,
               !r_first && !c_first};
    end else if (cmd.sum) begin
      pend <= pend & ~sel_oh;
    end
  end

  // Normalization datapath.
  logic signed [SUM_W-1:0] sx, sz;
  logic [2:0] cnt;
  logic [PW-1:0] oi, oj;
  logic run_last, grid_last;
  logic signed [SQ_W-1:0] sxe, sze;
  logic [SQ_W-1:0] sx2, sz2, sy2, qsum;
  logic [RAD_W-1:0] rad, root, rbit, trial;
  logic [LEN_W-1:0] len;
  logic [hvn_pkg::ITER_W-1:0] iter;
  logic [REM_W-1:0] rem [3];
  logic [REM_W-1:0] dsr;
  logic [QUO_W-1:0] quo [3];
  logic [SUM_W-1:0] mag [3];
  logic neg [3];

  assign sxe = sx;
  assign sze = sz;
  assign qsum = sx2 + sz2 + sy2;
  assign trial = root + rbit;
  assign len = (root[LEN_W-1:0] == '0) ? LEN_W'(1) : root[LEN_W-1:0];
  assign mag[0] = sx[SUM_W-1] ? SUM_W'(-sx) : SUM_W'(sx);
  assign mag[1] = SUM_W'({cnt, 8'd0});
  assign mag[2] = sz[SUM_W-1] ? SUM_W'(-sz) : SUM_W'(sz);
  assign neg[0] = sx[SUM_W-1];
  assign neg[1] = 1'b0;
  assign neg[2] = sz[SUM_W-1];

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sx <= sum_x;
      sz <= sum_z;
      cnt <= sum_n;
      oi <= vi;
      oj <= vj;
      run_last <= ((pend & ~sel_oh) == 4'd0);
      grid_last <= (vi == last_idx) && (vj == last_idx);
    end
    if (cmd.sq) begin
      sx2 <= sxe * sxe;
      sz2 <= sze * sze;
      sy2 <= SQ_W'({6'(cnt * cnt), 16'd0});
    end
    if (cmd.qsum) begin
      rad <= {qsum, 24'd0};
      root <= '0;
      rbit <= RAD_W'(1) << (RAD_W - 2);
      iter <= hvn_pkg::SQRT_STEPS_M1;
    end
    if (cmd.sqrt_step) begin
      if (rad >= trial) begin
        rad <= rad - trial;
        root <= (root >> 1) + rbit;
      end else begin
        root <= root >> 1;
      end
      rbit <= rbit >> 2;
      iter <= iter - 1'b1;
    end
    if (cmd.div_init) begin
      for (int q = 0; q < 3; q++) begin
        rem[q] <= REM_W'(mag[q]) << hvn_pkg::DIV_SHIFT;
        quo[q] <= '0;
      end
      dsr <= REM_W'(len) << (QUO_W - 1);
      iter <= hvn_pkg::DIV_STEPS_M1;
    end
    if (cmd.div_step) begin
      for (int q = 0; q < 3; q++) begin
        if (rem[q] >= dsr) begin
          rem[q] <= rem[q] - dsr;
          quo[q] <= {quo[q][QUO_W-2:0], 1'b1};
        end else begin
          quo[q] <= {quo[q][QUO_W-2:0], 1'b0};
        end
      end
      dsr <= dsr >> 1;
      iter <= iter - 1'b1;
    end
  end

  // Round half away from zero, limit to one, restore sign.
  logic [15:0] comp [3];
  logic [QUO_W:0] rnd [3];

  always_comb begin
    for (int q = 0; q < 3; q++) begin
      rnd[q] = ({1'b0, quo[q]} + (QUO_W + 1)'(1)) >> 1;
      comp[q] = (rnd[q] > 17'(hvn_pkg::UNIT_Q14)) ? hvn_pkg::UNIT_Q14 : rnd[q][15:0];
      if (neg[q]) begin
        comp[q] = -comp[q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.out_load) begin
      m_tdata <= {1'b0, 8'(oj), 8'(oi), comp[2], comp[1][14:0], comp[0]};
      m_tlast <= run_last;
      m_tuser <= grid_last;
    end
  end

  assign stat.has_pend = (pend != 4'd0);
  assign stat.iter_last = (iter == '0);
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

### rtl/heightmap_vertex_normals_top.sv
// Each result is worked out by a 32-step square root and a 16-step divide. The block holds
// one item at a time: it takes no new item until every result of the last one is out, and
// a stalled output holds it. An item in row 0 or column 0 gives no result.
// Reset (rst, synchronous, active high) clears the controller, grid position, window and
// output valid, and sets side_length to 256; the row buffers hold no reset.
module heightmap_vertex_normals_top #(
  parameter int MAX_SIDE = hvn_pkg::MAX_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] height
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] normal_x, [30:16] normal_y, [46:31] normal_z, [54:47] vertex_row,
  // [62:55] vertex_col, [63] zero
  output logic [63:0] m_tdata,
  output logic        m_tlast,   // last_of_run
  output logic        m_tuser,   // [0] grid_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [hvn_pkg::SIDE_W-1:0] side_length;
  logic cfg_wr;
  hvn_pkg::cmd_t cmd;
  hvn_pkg::stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == hvn_pkg::REG_SIDE);
  assign prdata = (paddr[2] == hvn_pkg::REG_SIDE) ? 32'(side_length) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= hvn_pkg::SIDE_RESET;
    end else if (cfg_wr) begin
      side_length <= pwdata[hvn_pkg::SIDE_W-1:0];
    end
  end

  hvn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .stat(stat), .cmd(cmd)
  );

  hvn_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .side_length(side_length), .cfg_wr(cfg_wr), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

endmodule

### rtl/hvn_checker.sv
module hvn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // The block holds one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after an item");

  // The final vertex of the grid is always the final result of its item.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("grid_done without last_of_run");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind heightmap_vertex_normals_top hvn_checker u_hvn_checker (.*);

### tb/sv/heightmap_vertex_normals_top_tb.sv
`timescale 1ns / 100ps

module heightmap_vertex_normals_top_tb;

  localparam int GRID_MAX = 256;
  localparam int SETTLE_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES = 1500;

  typedef struct packed {
    logic [15:0] nx;
    logic [14:0] ny;
    logic [15:0] nz;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        last;
    logic        done;
  } normal_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  heightmap_vertex_normals_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Predictor state.
  logic [8:0] side_reg = hvn_pkg::SIDE_RESET;
  int         older_row [GRID_MAX];
  int         prev_row [GRID_MAX];
  int         win [3][3];
  int         cur_row = 0;
  int         cur_col = 0;
  int         win_r0;
  int         win_c0;
  longint     acc_x;
  longint     acc_y;
  longint     acc_z;

  normal_t    expected_normals[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  bit         hold_req = 1'b0;
  bit         burst_mode = 1'b0;

  function automatic int grid_side();
    if (side_reg < 2) return 2;
    if (side_reg > GRID_MAX) return GRID_MAX;
    return int'(side_reg);
  endfunction

  function automatic longint win_h(int gr, int gc);
    int t;
    int k;
    t = gr - win_r0;
    k = gc - win_c0;
    if (t < 0 || t > 2 || k < 0 || k > 2) return 0;
    return win[t][k];
  endfunction

  function automatic void add_face(int m, int n, bit upper, int side);
    longint a;
    longint b;
    longint d;
    longint e;
    if (m < 0 || n < 0 || m > side - 2 || n > side - 2) return;
    a = win_h(m, n);
    b = win_h(m, n + 1);
    d = win_h(m + 1, n);
    e = win_h(m + 1, n + 1);
    if (!upper) begin
      acc_x += a - b;
      acc_z += a - d;
    end else begin
      acc_x += d - e;
      acc_z += b - e;
    end
    acc_y += 256;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bit_v;
    res = 0;
    bit_v = 64'h4000_0000_0000_0000;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] unit_comp(longint s, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    q = ((mag << 27) / len + 1) >> 1;
    if (q > 16384) q = 16384;
    if (s < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic void push_normal(int i, int j, int side);
    longint unsigned sq;
    longint unsigned len;
    logic [15:0] y;
    normal_t n;
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    add_face(i - 1, j - 1, 1'b1, side);
    add_face(i - 1, j, 1'b0, side);
    add_face(i - 1, j, 1'b1, side);
    add_face(i, j - 1, 1'b0, side);
    add_face(i, j - 1, 1'b1, side);
    add_face(i, j, 1'b0, side);
    sq = acc_x * acc_x + acc_y * acc_y + acc_z * acc_z;
    len = int_sqrt(sq << 24);
    if (len == 0) len = 1;
    y = unit_comp(acc_y, len);
    n.nx = unit_comp(acc_x, len);
    n.ny = y[14:0];
    n.nz = unit_comp(acc_z, len);
    n.row = i[7:0];
    n.col = j[7:0];
    n.last = 1'b0;
    n.done = (i == side - 1 && j == side - 1);
    expected_normals.insert(expected_normals.size(), n);
  endfunction

  function automatic void predict_normals(logic [15:0] din);
    int side;
    int r;
    int c;
    int h;
    int n;
    side = grid_side();
    r = cur_row;
    c = cur_col;
    n = 0;
    if (r >= side || c >= side) begin
      r = 0;
      c = 0;
    end
    h = int'($signed(din));
    for (int t = 0; t < 3; t++) begin
      win[t][0] = win[t][1];
      win[t][1] = win[t][2];
    end
    win[0][2] = older_row[c];
    win[1][2] = prev_row[c];
    older_row[c] = prev_row[c];
    prev_row[c] = h;
    win[2][2] = h;
    win_r0 = r - 2;
    win_c0 = c - 2;
    if (r >= 1 && c >= 1) begin push_normal(r - 1, c - 1, side); n++; end
    if (r >= 1 && c == side - 1) begin push_normal(r - 1, c, side); n++; end
    if (r == side - 1 && c >= 1) begin push_normal(r, c - 1, side); n++; end
    if (r == side - 1 && c == side - 1) begin push_normal(r, c, side); n++; end
    if (n > 0) expected_normals[$].last = 1'b1;
    c++;
    if (c >= side) begin
      c = 0;
      r++;
      if (r >= side) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endfunction

  // Watchdog on cycles in which no handshake completes.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result checker with random backpressure.
  initial begin : result_sink
    int stall;
    normal_t exp_n;
    normal_t got;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 19);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.nx = m_tdata[15:0];
      got.ny = m_tdata[30:16];
      got.nz = m_tdata[46:31];
      got.row = m_tdata[54:47];
      got.col = m_tdata[62:55];
      got.last = m_tlast;
      got.done = m_tuser;
      if (expected_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected normal row %0d col %0d", got.row, got.col);
      end else begin
        exp_n = expected_normals.pop_front();
        if (got != exp_n || m_tdata[63] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Normal mismatch: expected x %h y %h z %h r %0d c %0d l %b d %b, ",
                     exp_n.nx, exp_n.ny, exp_n.nz, exp_n.row, exp_n.col, exp_n.last,
                     exp_n.done, "got x %h y %h z %h r %0d c %0d l %b d %b",
                     got.nx, got.ny, got.nz, got.row, got.col, got.last, got.done);
        end
      end
    end
  end

  task automatic send_height(logic [15:0] h);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= h;
    do @(posedge clk); while (!s_tready);
    predict_normals(h);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(logic [8:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * hvn_pkg::REG_SIDE);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    side_reg = value;
    cur_row = 0;
    cur_col = 0;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[8:0] !== value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Side readback: expected %0d got %0d", value, prdata[8:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [15:0] rand_height();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_grid(int count);
    for (int k = 0; k < count; k++) send_height(rand_height());
  endtask

  // Side left at its reset value: the first row emits nothing.
  task automatic test_reset_side();
    send_grid(12);
    drain();
  endtask

  // Side values below the minimum, extreme heights, flat terrain and grid wrap.
  task automatic test_directed();
    write_side(9'd0);
    send_height(16'h8000);
    send_height(16'h7fff);
    send_height(16'h7fff);
    send_height(16'h8000);
    for (int k = 0; k < 4; k++) send_height(16'h0000);
    drain();
    write_side(9'd1);
    send_height(16'hffff);
    send_height(16'h0001);
    drain();
    write_side(9'd3);
    send_height(16'h7fff);
    send_height(16'h8000);
    send_height(16'h7fff);
    send_height(16'h8000);
    send_height(16'h7fff);
    send_height(16'h8000);
    send_height(16'h5555);
    send_height(16'haaaa);
    send_height(16'h0000);
    drain();
  endtask

  // Side above the maximum saturates to the largest grid.
  task automatic test_saturated_side();
    write_side(9'd511);
    send_grid(6);
    drain();
    write_side(9'd300);
    send_grid(4);
    drain();
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    write_side(9'd4);
    hold_req = 1'b1;
    send_grid(16);
    drain();
  endtask

  task automatic test_random();
    int items;
    int side;
    int count;
    items = 0;
    while (items < 45) begin
      side = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(2, 5);
      burst_mode = ($urandom_range(0, 3) == 0);
      write_side(9'(side));
      case ($urandom_range(0, 5))
        0: count = $urandom_range(1, side * side - 1);
        1: count = side * side + side + 1;
        default: count = side * side;
      endcase
      send_grid(count);
      items += count;
      drain();
    end
    burst_mode = 1'b0;
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_side();
    test_directed();
    test_saturated_side();
    test_backpressure();
    test_random();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
